// File: src/pga_pkg.sv
// Shared constants, codes and control types of the photogate pendulum analyser.
package pga_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int LOG2_FB       = 28;

  localparam logic [33:0] LN2_Q30     = 34'd744261118;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [33:0] INERTIA_K   = 34'd4582269852;
  localparam logic [35:0] SPEED_MAX   = 36'hFFFFFFFFF;
  localparam logic [47:0] INERTIA_MAX = 48'hFFFFFFFFFFFF;
  localparam logic [19:0] US_PER_S    = 20'd1000000;

  localparam logic [1:0] CFG_FLAG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_MASS       = 2'd1;
  localparam logic [1:0] CFG_PIVOT      = 2'd2;

  localparam logic [15:0] FLAG_WIDTH_RST = 16'd5000;
  localparam logic [15:0] MASS_RST       = 16'd1500;
  localparam logic [15:0] PIVOT_RST      = 16'd400;

  // Width of the shared divider: the speed numerator or the damping numerator.
  function automatic int div_width(input int frac_bits);
    return (2 * frac_bits + 6 > 36) ? 2 * frac_bits + 6 : 36;
  endfunction

  typedef enum logic [4:0] {
    OP_NONE,
    OP_BLOCK,
    OP_LEVEL,
    OP_HIT,
    OP_DIV,
    OP_SPEED,
    OP_NSTEP,
    OP_MLOAD,
    OP_SQ,
    OP_MAG,
    OP_DMAG,
    OP_SSQ,
    OP_SQRT,
    OP_ZSET,
    OP_ZETA,
    OP_ISQ,
    OP_ILO,
    OP_IHI,
    OP_ISAT,
    OP_ILOADA,
    OP_IK0,
    OP_IK1,
    OP_IK2,
    OP_IFIN,
    OP_EMIT
  } pga_op_e;

  typedef struct packed {
    logic    take;
    pga_op_e op;
  } pga_cmd_t;

  typedef struct packed {
    logic lvl_same;
    logic lvl_low;
    logic blocking;
    logic tau_zero;
    logic x_top;
    logic speed_nz;
    logic dec_ok;
    logic acc_big;
    logic inr_go;
    logic out_free;
  } pga_stat_t;

endpackage

// File: src/photogate_pendulum_analyzer.sv
// Top level of the photogate pendulum analyser: controller and datapath.
// An edge that yields no word is taken in S_IDLE and retired from S_EVAL.
// A completed block runs two NW-step divisions, NW = max(36, 2*FRAC_BITS+6),
// the normalising steps, 28 log squarings, 30 root digits and the inertia
// multiply steps, all sharing one datapath.
// One edge is worked on at a time; a finished word waits in the output register.
// Reset clears the state and loads the default flag width, mass and pivot distance.
module photogate_pendulum_analyzer #(
  parameter int FRAC_BITS = pga_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               gate_level_i,
  input  logic [31:0]        time_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        hit_number_o,
  output logic [31:0]        block_us_o,
  output logic [35:0]        speed_um_s_o,
  output logic               period_ok_o,
  output logic [32:0]        period_us_o,
  output logic               decrement_ok_o,
  output logic signed [23:0] log_decrement_o,
  output logic signed [17:0] damping_ratio_o,
  output logic               inertia_ok_o,
  output logic [47:0]        inertia_gmm2_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import pga_pkg::*;

  pga_cmd_t  cmd;
  pga_stat_t stat;

  pga_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pga_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .gate_level_i    (gate_level_i),
    .time_us_i       (time_us_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_number_o    (hit_number_o),
    .block_us_o      (block_us_o),
    .speed_um_s_o    (speed_um_s_o),
    .period_ok_o     (period_ok_o),
    .period_us_o     (period_us_o),
    .decrement_ok_o  (decrement_ok_o),
    .log_decrement_o (log_decrement_o),
    .damping_ratio_o (damping_ratio_o),
    .inertia_ok_o    (inertia_ok_o),
    .inertia_gmm2_o  (inertia_gmm2_o)
  );

endmodule

// File: src/pga_ctrl.sv
// Sequencing state machine of the photogate pendulum analyser.
module pga_ctrl #(
  parameter int FRAC_BITS = pga_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pga_pkg::pga_stat_t stat_i,
  output pga_pkg::pga_cmd_t  cmd_o
);
  import pga_pkg::*;

  localparam int NW = div_width(FRAC_BITS);
  localparam int CW = $clog2(NW);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_EVAL = 5'd1;
  localparam logic [4:0] S_DIVS = 5'd2;
  localparam logic [4:0] S_SPD  = 5'd3;
  localparam logic [4:0] S_NORM = 5'd4;
  localparam logic [4:0] S_SQ   = 5'd5;
  localparam logic [4:0] S_MAG  = 5'd6;
  localparam logic [4:0] S_DMAG = 5'd7;
  localparam logic [4:0] S_SSQ  = 5'd8;
  localparam logic [4:0] S_SQRT = 5'd9;
  localparam logic [4:0] S_ZSET = 5'd10;
  localparam logic [4:0] S_DIVZ = 5'd11;
  localparam logic [4:0] S_ZETA = 5'd12;
  localparam logic [4:0] S_I1   = 5'd13;
  localparam logic [4:0] S_I2   = 5'd14;
  localparam logic [4:0] S_I3   = 5'd15;
  localparam logic [4:0] S_I4   = 5'd16;
  localparam logic [4:0] S_I5   = 5'd17;
  localparam logic [4:0] S_I6   = 5'd18;
  localparam logic [4:0] S_I7   = 5'd19;
  localparam logic [4:0] S_I8   = 5'd20;
  localparam logic [4:0] S_EMIT = 5'd21;

  logic [4:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [4:0]    after_speed;

  assign after_speed = stat_i.inr_go ? S_I1 : S_EMIT;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.take = 1'b0;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.lvl_same) begin
          state_d = S_IDLE;
        end else if (stat_i.lvl_low) begin
          cmd_o.op = OP_BLOCK;
          state_d  = S_IDLE;
        end else if (!stat_i.blocking) begin
          cmd_o.op = OP_LEVEL;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_HIT;
          cnt_d    = CW'(NW - 1);
          state_d  = stat_i.tau_zero ? S_NORM : S_DIVS;
        end
      end
      S_DIVS: begin
        cmd_o.op = OP_DIV;
        if (cnt_q == '0) state_d = S_SPD;
        else cnt_d = cnt_q - 1'b1;
      end
      S_SPD: begin
        cmd_o.op = OP_SPEED;
        state_d  = S_NORM;
      end
      S_NORM: begin
        if (!stat_i.speed_nz) begin
          state_d = after_speed;
        end else if (stat_i.x_top) begin
          cmd_o.op = OP_MLOAD;
          cnt_d    = CW'(LOG2_FB - 1);
          state_d  = S_SQ;
        end else begin
          cmd_o.op = OP_NSTEP;
        end
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        if (cnt_q == '0) state_d = stat_i.dec_ok ? S_MAG : after_speed;
        else cnt_d = cnt_q - 1'b1;
      end
      S_MAG: begin
        cmd_o.op = OP_MAG;
        state_d  = S_DMAG;
      end
      S_DMAG: begin
        cmd_o.op = OP_DMAG;
        state_d  = S_SSQ;
      end
      S_SSQ: begin
        cmd_o.op = OP_SSQ;
        cnt_d    = CW'(29);
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (cnt_q == '0) state_d = S_ZSET;
        else cnt_d = cnt_q - 1'b1;
      end
      S_ZSET: begin
        cmd_o.op = OP_ZSET;
        cnt_d    = CW'(NW - 1);
        state_d  = S_DIVZ;
      end
      S_DIVZ: begin
        cmd_o.op = OP_DIV;
        if (cnt_q == '0) state_d = S_ZETA;
        else cnt_d = cnt_q - 1'b1;
      end
      S_ZETA: begin
        cmd_o.op = OP_ZETA;
        state_d  = after_speed;
      end
      S_I1: begin
        cmd_o.op = OP_ISQ;
        state_d  = S_I2;
      end
      S_I2: begin
        cmd_o.op = OP_ILO;
        state_d  = S_I3;
      end
      S_I3: begin
        cmd_o.op = OP_IHI;
        state_d  = S_I4;
      end
      S_I4: begin
        if (stat_i.acc_big) begin
          cmd_o.op = OP_ISAT;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = OP_ILOADA;
          state_d  = S_I5;
        end
      end
      S_I5: begin
        cmd_o.op = OP_IK0;
        state_d  = S_I6;
      end
      S_I6: begin
        cmd_o.op = OP_IK1;
        state_d  = S_I7;
      end
      S_I7: begin
        cmd_o.op = OP_IK2;
        state_d  = S_I8;
      end
      S_I8: begin
        cmd_o.op = OP_IFIN;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: src/pga_dpath.sv
// Datapath of the photogate pendulum analyser: state, divider, logarithm, root, multiplier.
module pga_dpath #(
  parameter int FRAC_BITS = pga_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pga_pkg::pga_cmd_t  cmd_i,
  output pga_pkg::pga_stat_t stat_o,
  input  logic               gate_level_i,
  input  logic [31:0]        time_us_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        hit_number_o,
  output logic [31:0]        block_us_o,
  output logic [35:0]        speed_um_s_o,
  output logic               period_ok_o,
  output logic [32:0]        period_us_o,
  output logic               decrement_ok_o,
  output logic signed [23:0] log_decrement_o,
  output logic signed [17:0] damping_ratio_o,
  output logic               inertia_ok_o,
  output logic [47:0]        inertia_gmm2_o
);
  import pga_pkg::*;

  localparam int NW  = div_width(FRAC_BITS);
  localparam int DMW = FRAC_BITS + 5;
  localparam logic [63:0] FP2_FULL = PI_Q30 * PI_Q30;
  localparam logic [59:0] FP2      = 60'(FP2_FULL >> (58 - 2 * FRAC_BITS));
  localparam logic [63:0] DM_RND   = 64'(1) << (57 - FRAC_BITS);

  // Configuration and architectural state.
  logic [15:0]  fw_q, mass_q, pivot_q;
  logic         prior_level_q, blocking_q, seen_hit_q, seen_speed_q, prior_nz_q;
  logic [31:0]  block_start_q, last_hit_q, hit_total_q;
  logic [32:0]  held_period_q;
  logic         period_ok_q, inertia_ok_q;
  logic [47:0]  held_inertia_q;
  logic [33:0]  prior_log_q;

  // Working registers of one hit.
  logic         lvl_q;
  logic [31:0]  t_q, tau_q;
  logic [35:0]  speed_q, x_q;
  logic [5:0]   e_q;
  logic [31:0]  m_q;
  logic [27:0]  frac_q;
  logic [NW-1:0] num_q, zmag_q;
  logic [31:0]  rem_q, den_q;
  logic [33:0]  mag_q;
  logic         neg_q;
  logic [DMW-1:0] dmag_q;
  logic [59:0]  rad_q;
  logic [31:0]  srem_q;
  logic [29:0]  root_q;
  logic [65:0]  x2_q;
  logic [31:0]  p_q;
  logic [79:0]  a_q;
  logic [113:0] acc_q;

  logic         out_valid_q;

  // Shared multiplier.
  logic [33:0] mul_a, mul_b;
  logic [67:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_SQ: begin
        mul_a = 34'(m_q);
        mul_b = 34'(m_q);
      end
      OP_DMAG: begin
        mul_a = mag_q;
        mul_b = LN2_Q30;
      end
      OP_SSQ: begin
        mul_a = 34'(dmag_q);
        mul_b = 34'(dmag_q);
      end
      OP_ISQ: begin
        mul_a = 34'(held_period_q);
        mul_b = 34'(held_period_q);
      end
      OP_ILO: begin
        mul_a = x2_q[33:0];
        mul_b = 34'(p_q);
      end
      OP_IHI: begin
        mul_a = 34'(x2_q[65:34]);
        mul_b = 34'(p_q);
      end
      OP_IK0: begin
        mul_a = a_q[33:0];
        mul_b = INERTIA_K;
      end
      OP_IK1: begin
        mul_a = a_q[67:34];
        mul_b = INERTIA_K;
      end
      OP_IK2: begin
        mul_a = 34'(a_q[79:68]);
        mul_b = INERTIA_K;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 68'(mul_a) * 68'(mul_b);

  logic [31:0] tau_w, half_w;
  assign tau_w  = t_q - block_start_q;
  assign half_w = t_q - last_hit_q;

  // One restoring division step.
  logic [32:0] div_r2;
  logic        div_ge;
  assign div_r2 = {rem_q, num_q[NW-1]};
  assign div_ge = div_r2 >= {1'b0, den_q};

  // One digit of the square root.
  logic [33:0] sq_r2, sq_trial;
  logic        sq_ge;
  assign sq_r2    = {srem_q, rad_q[59:58]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_r2 >= sq_trial;

  // One squaring step of the log mantissa.
  logic [32:0] sq_v;
  assign sq_v = prod[63:31];

  logic [33:0] cur_log;
  assign cur_log = {e_q, frac_q};

  logic [63:0] dm_sum;
  assign dm_sum = prod[63:0] + DM_RND;

  logic [113:0] fin_sum;
  logic [49:0]  fin_q;
  assign fin_sum = acc_q + {50'd0, 1'b1, 63'd0};
  assign fin_q   = fin_sum[113:64];

  logic dec_ok_w;
  assign dec_ok_w = seen_speed_q & prior_nz_q & (speed_q != '0);

  // Saturated, signed decrement and damping ratio.
  logic [31:0] dm32;
  logic [63:0] zm64;
  logic [23:0] dsat;
  logic [17:0] zsat;
  always_comb begin
    dm32 = 32'(dmag_q);
    zm64 = 64'(zmag_q);
    if (!dec_ok_w) begin
      dsat = '0;
      zsat = '0;
    end else if (!neg_q) begin
      dsat = (dm32 > 32'd8388607) ? 24'h7FFFFF : dm32[23:0];
      zsat = (zm64 > 64'd131071) ? 18'h1FFFF : zm64[17:0];
    end else begin
      dsat = (dm32 > 32'd8388608) ? 24'h800000 : 24'(-dm32);
      zsat = (zm64 > 64'd131072) ? 18'h20000 : 18'(-zm64);
    end
  end

  assign stat_o.lvl_same = (lvl_q == prior_level_q);
  assign stat_o.lvl_low  = !lvl_q;
  assign stat_o.blocking = blocking_q;
  assign stat_o.tau_zero = (tau_w == '0);
  assign stat_o.x_top    = x_q[35];
  assign stat_o.speed_nz = (speed_q != '0);
  assign stat_o.dec_ok   = dec_ok_w;
  assign stat_o.acc_big  = (acc_q[113:80] != '0);
  assign stat_o.inr_go   = period_ok_q & (mass_q != '0) & (pivot_q != '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // State that reset defines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q           <= FLAG_WIDTH_RST;
      mass_q         <= MASS_RST;
      pivot_q        <= PIVOT_RST;
      prior_level_q  <= 1'b1;
      blocking_q     <= 1'b0;
      block_start_q  <= '0;
      seen_hit_q     <= 1'b0;
      last_hit_q     <= '0;
      hit_total_q    <= '0;
      seen_speed_q   <= 1'b0;
      prior_nz_q     <= 1'b0;
      held_period_q  <= '0;
      period_ok_q    <= 1'b0;
      held_inertia_q <= '0;
      inertia_ok_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FLAG_WIDTH: fw_q    <= cfg_data_i;
          CFG_MASS:       mass_q  <= cfg_data_i;
          CFG_PIVOT:      pivot_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_EMIT) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (cmd_i.op)
        OP_BLOCK: begin
          prior_level_q <= 1'b0;
          blocking_q    <= 1'b1;
          block_start_q <= t_q;
        end
        OP_LEVEL: prior_level_q <= lvl_q;
        OP_HIT: begin
          prior_level_q <= 1'b1;
          blocking_q    <= 1'b0;
          if (seen_hit_q) begin
            held_period_q <= {half_w, 1'b0};
            period_ok_q   <= (half_w != '0);
          end
          seen_hit_q  <= 1'b1;
          last_hit_q  <= t_q;
          hit_total_q <= hit_total_q + 32'd1;
        end
        OP_ISAT: begin
          held_inertia_q <= INERTIA_MAX;
          inertia_ok_q   <= 1'b1;
        end
        OP_IFIN: begin
          held_inertia_q <= (fin_q[49:48] != '0) ? INERTIA_MAX : fin_q[47:0];
          inertia_ok_q   <= 1'b1;
        end
        OP_EMIT: begin
          seen_speed_q <= 1'b1;
          prior_nz_q   <= (speed_q != '0);
        end
        default: ;
      endcase
    end
  end

  // Working registers and the output word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      lvl_q <= gate_level_i;
      t_q   <= time_us_i;
    end
    unique case (cmd_i.op)
      OP_HIT: begin
        tau_q <= tau_w;
        if (tau_w == '0) begin
          speed_q <= SPEED_MAX;
          x_q     <= SPEED_MAX;
          e_q     <= 6'd35;
        end else begin
          num_q <= NW'(36'(fw_q) * 36'(US_PER_S)) + NW'(tau_w >> 1);
          rem_q <= '0;
          den_q <= tau_w;
        end
      end
      OP_DIV: begin
        num_q <= {num_q[NW-2:0], div_ge};
        rem_q <= div_ge ? 32'(div_r2 - {1'b0, den_q}) : div_r2[31:0];
      end
      OP_SPEED: begin
        speed_q <= num_q[35:0];
        x_q     <= num_q[35:0];
        e_q     <= 6'd35;
      end
      OP_NSTEP: begin
        x_q <= {x_q[34:0], 1'b0};
        e_q <= e_q - 6'd1;
      end
      OP_MLOAD: begin
        m_q    <= x_q[35:4];
        frac_q <= '0;
      end
      OP_SQ: begin
        if (sq_v[32]) begin
          m_q    <= sq_v[32:1];
          frac_q <= {frac_q[26:0], 1'b1};
        end else begin
          m_q    <= sq_v[31:0];
          frac_q <= {frac_q[26:0], 1'b0};
        end
      end
      OP_MAG: begin
        neg_q <= cur_log > prior_log_q;
        mag_q <= (cur_log > prior_log_q) ? cur_log - prior_log_q : prior_log_q - cur_log;
      end
      OP_DMAG: dmag_q <= DMW'(dm_sum >> (58 - FRAC_BITS));
      OP_SSQ: begin
        rad_q  <= FP2 + prod[59:0];
        srem_q <= '0;
        root_q <= '0;
      end
      OP_SQRT: begin
        rad_q  <= {rad_q[57:0], 2'b00};
        srem_q <= sq_ge ? 32'(sq_r2 - sq_trial) : sq_r2[31:0];
        root_q <= {root_q[28:0], sq_ge};
      end
      OP_ZSET: begin
        num_q <= (NW'(dmag_q) << FRAC_BITS) + NW'(root_q >> 1);
        rem_q <= '0;
        den_q <= 32'(root_q);
      end
      OP_ZETA: zmag_q <= num_q;
      OP_ISQ: begin
        x2_q <= prod[65:0];
        p_q  <= 32'(mass_q) * 32'(pivot_q);
      end
      OP_ILO:    acc_q <= 114'(prod);
      OP_IHI:    acc_q <= acc_q + (114'(prod) << 34);
      OP_ILOADA: begin
        a_q   <= acc_q[79:0];
        acc_q <= '0;
      end
      OP_IK0: acc_q <= acc_q + 114'(prod);
      OP_IK1: acc_q <= acc_q + (114'(prod) << 34);
      OP_IK2: acc_q <= acc_q + (114'(prod) << 68);
      OP_EMIT: begin
        prior_log_q     <= cur_log;
        hit_number_o    <= hit_total_q;
        block_us_o      <= tau_q;
        speed_um_s_o    <= speed_q;
        period_ok_o     <= period_ok_q;
        period_us_o     <= held_period_q;
        decrement_ok_o  <= dec_ok_w;
        log_decrement_o <= dsat;
        damping_ratio_o <= zsat;
        inertia_ok_o    <= inertia_ok_q;
        inertia_gmm2_o  <= held_inertia_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/pga_check.sv
// Port-level checks of the photogate pendulum analyser, bound to the top level.
module pga_check (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [31:0]        hit_number_o,
  input logic               period_ok_o,
  input logic [32:0]        period_us_o,
  input logic               decrement_ok_o,
  input logic signed [23:0] log_decrement_o,
  input logic signed [17:0] damping_ratio_o
);

  // A stalled word keeps its hit count.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_number_o))
    else $error("output word changed while stalled");

  // Without a valid decrement both decrement fields read zero.
  a_dec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !decrement_ok_o |-> log_decrement_o == 0 && damping_ratio_o == 0)
    else $error("decrement fields nonzero while invalid");

  // The held period is zero whenever it is not valid.
  a_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !period_ok_o |-> period_us_o == 0)
    else $error("period nonzero while invalid");

  // The damping ratio never has the opposite sign to the decrement.
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && log_decrement_o < 0 |-> damping_ratio_o <= 0)
    else $error("damping ratio sign disagrees with decrement");

endmodule

bind photogate_pendulum_analyzer pga_check u_pga_check (.*);
